// ===== rtl/cqsa_pkg.sv =====
package cqsa_pkg;

  localparam int DATA_W = 32;
  localparam int REQ_W = 31;
  localparam int VER_W = 64;
  localparam int LW_W = 5;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DISCARD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_WATER = 1'b1;

  localparam logic [DATA_W-1:0] DISCARD_RESET = '0;
  localparam logic [LW_W-1:0] LOW_WATER_RESET = 5'd2;

  // input item function codes
  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RETRY    = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_CORRUPT  = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef struct packed {
    logic              func;
    logic [DATA_W-1:0] chunk_id;
    logic [DATA_W-1:0] chunk_bytes;
    logic [DATA_W-1:0] chunk_fill_start;
    logic [REQ_W-1:0]  request_bytes;
    logic              normal_priority;
  } in_item_t;

  typedef struct packed {
    logic              grant_valid;
    logic [DATA_W-1:0] grant_chunk;
    logic [DATA_W-1:0] grant_offset;
    logic [DATA_W-1:0] grant_length;
    logic [VER_W-1:0]  grant_version;
    status_e           status;
    logic              refill_needed;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] id;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] fill;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic calc_room;
    logic decide;
    logic grant;
    logic push;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_add;
    logic spilled;
    logic to_fetch;
    logic to_grant;
  } dp_sts_t;

  function automatic out_item_t err_item(status_e st);
    out_item_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  function automatic out_item_t grant_item(logic [DATA_W-1:0] id, logic [DATA_W-1:0] off,
                                           logic [DATA_W-1:0] len, logic [VER_W-1:0] ver);
    out_item_t r;
    r = '0;
    r.grant_valid = 1'b1;
    r.grant_chunk = id;
    r.grant_offset = off;
    r.grant_length = len;
    r.grant_version = ver;
    r.status = ST_OK;
    return r;
  endfunction

endpackage

// ===== rtl/cqsa_ctrl.sv =====
module cqsa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 push_ok_i,
  input  cqsa_pkg::dp_sts_t    sts_i,
  output cqsa_pkg::ctrl_cmd_t  cmd_o
);
  import cqsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOM,
    S_DECIDE,
    S_FETCH,
    S_GRANT,
    S_PUSH
  } state_e;

  state_e state_q;
  logic   stall_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = (state_q == S_IDLE) && in_valid_i;
    cmd_o.calc_room = (state_q == S_ROOM);
    cmd_o.decide = (state_q == S_DECIDE);
    cmd_o.grant = (state_q == S_GRANT);
    cmd_o.push = (state_q == S_PUSH) && push_ok_i;
  end

  assign in_stall_o = stall_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stall_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_ROOM;
            stall_q <= 1'b1;
          end
        end
        S_ROOM: begin
          // second pass after a spill goes straight to the grant
          state_q <= sts_i.spilled ? S_GRANT : S_DECIDE;
        end
        S_DECIDE: begin
          if (sts_i.is_add) begin
            state_q <= S_PUSH;
          end else if (sts_i.to_fetch) begin
            state_q <= S_FETCH;
          end else if (sts_i.to_grant) begin
            state_q <= S_GRANT;
          end else begin
            state_q <= S_PUSH;
          end
        end
        S_FETCH: begin
          state_q <= S_ROOM;
        end
        S_GRANT: begin
          state_q <= S_PUSH;
        end
        S_PUSH: begin
          if (push_ok_i) begin
            state_q <= S_IDLE;
            stall_q <= 1'b0;
          end
        end
        default: begin
          state_q <= S_IDLE;
          stall_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/cqsa_dp.sv =====
module cqsa_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ALIGN_BYTES = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cqsa_pkg::in_item_t                   in_data_i,
  input  logic                                 cfg_we_i,
  input  logic [cqsa_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [cqsa_pkg::DATA_W-1:0]          cfg_wdata_i,
  input  cqsa_pkg::ctrl_cmd_t                  cmd_i,
  output cqsa_pkg::dp_sts_t                    sts_o,
  output cqsa_pkg::out_item_t                  res0_o,
  output cqsa_pkg::out_item_t                  res1_o,
  output logic                                 two_o
);
  import cqsa_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > LW_W) ? CNT_W : LW_W;
  localparam logic [DATA_W-1:0] ALIGN_MASK = DATA_W'(ALIGN_BYTES - 1);

  // queue storage, reset-less
  entry_t mem_q [QUEUE_DEPTH];
  entry_t rd_q;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  logic [IDX_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [VER_W-1:0]  ver_q, ver_d;
  logic              refill_q, refill_d;
  logic              spilled_q, spilled_d;
  logic [DATA_W-1:0] discard_q, discard_d;
  logic [LW_W-1:0]   lw_q, lw_d;

  in_item_t          item_q, item_d;
  logic [DATA_W-1:0] need_q, need_d;
  logic signed [DATA_W:0] room_q, room_d;
  out_item_t         res0_q, res0_d, res1_q, res1_d;
  logic              two_q, two_d;

  logic [DATA_W-1:0] need_calc;
  logic signed [DATA_W:0] room_calc;
  logic              room_lt_need, room_le_zero, low_single, cnt_zero, full;
  logic [IDX_W-1:0]  head_nxt, tail_nxt;
  logic [CNT_W-1:0]  cnt_dec;
  logic              cnt_low;
  logic [VER_W-1:0]  ver_inc;
  logic [DATA_W-1:0] room_after;
  status_e           empty_st;
  out_item_t         gres;

  assign need_calc = (DATA_W'(in_data_i.request_bytes) + ALIGN_MASK) & ~ALIGN_MASK;
  assign room_calc = $signed({1'b0, rd_q.size}) - $signed({1'b0, rd_q.fill});
  assign room_lt_need = room_q < $signed({1'b0, need_q});
  assign room_le_zero = room_q[DATA_W] || (room_q == '0);
  assign low_single = !item_q.normal_priority && (cnt_q <= CNT_W'(1));
  assign cnt_zero = (cnt_q == '0);
  assign full = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign head_nxt = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_nxt = (tail_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign cnt_dec = cnt_q - 1'b1;
  assign cnt_low = CMP_W'(cnt_dec) < CMP_W'(lw_q);
  assign ver_inc = ver_q + 1'b1;
  assign room_after = room_q[DATA_W-1:0] - need_q;
  assign empty_st = item_q.normal_priority ? ST_NO_SPACE : ST_RETRY;

  always_comb begin
    sts_o = '0;
    sts_o.is_add = (item_q.func == FUNC_ADD);
    sts_o.spilled = spilled_q;
    // spill that leaves a chunk behind needs a read of the new head
    sts_o.to_fetch = !cnt_zero && room_lt_need && !low_single && !room_le_zero &&
                     (cnt_q != CNT_W'(1));
    sts_o.to_grant = !cnt_zero && !room_lt_need;
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d = cnt_q;
    ver_d = ver_q;
    refill_d = refill_q;
    spilled_d = spilled_q;
    discard_d = discard_q;
    lw_d = lw_q;
    item_d = item_q;
    need_d = need_q;
    room_d = room_q;
    res0_d = res0_q;
    res1_d = res1_q;
    two_d = two_q;
    wr_en = 1'b0;
    wr_addr = head_q;
    wr_data = rd_q;
    gres = grant_item(rd_q.id, rd_q.fill, need_q, ver_inc);

    if (cmd_i.load) begin
      item_d = in_data_i;
      need_d = need_calc;
      refill_d = 1'b0;
      spilled_d = 1'b0;
    end

    if (cmd_i.calc_room) begin
      room_d = room_calc;
    end

    if (cmd_i.decide) begin
      two_d = 1'b0;
      if (item_q.func == FUNC_ADD) begin
        if (full) begin
          res0_d = err_item(ST_FULL);
        end else begin
          wr_en = 1'b1;
          wr_addr = tail_q;
          wr_data.id = item_q.chunk_id;
          wr_data.size = item_q.chunk_bytes;
          wr_data.fill = item_q.chunk_fill_start;
          tail_d = tail_nxt;
          cnt_d = cnt_q + 1'b1;
          res0_d = err_item(ST_OK);
        end
      end else if (cnt_zero) begin
        res0_d = err_item(empty_st);
      end else if (room_lt_need) begin
        if (low_single) begin
          res0_d = err_item(ST_RETRY);
        end else if (room_le_zero) begin
          res0_d = err_item(ST_CORRUPT);
        end else begin
          // hand out the whole remainder and retire the head
          wr_en = 1'b1;
          wr_data.fill = rd_q.size;
          res0_d = grant_item(rd_q.id, rd_q.fill, room_q[DATA_W-1:0], ver_inc);
          ver_d = ver_inc;
          need_d = need_q - room_q[DATA_W-1:0];
          head_d = head_nxt;
          cnt_d = cnt_dec;
          if (cnt_low) begin
            refill_d = 1'b1;
          end
          spilled_d = 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            res1_d = err_item(empty_st);
            two_d = 1'b1;
          end
        end
      end
    end

    if (cmd_i.grant) begin
      if (room_lt_need) begin
        gres = err_item(ST_RETRY);
      end else begin
        wr_en = 1'b1;
        wr_data.fill = rd_q.fill + need_q;
        ver_d = ver_inc;
        if (room_after < discard_q) begin
          head_d = head_nxt;
          cnt_d = cnt_dec;
          if (cnt_low) begin
            refill_d = 1'b1;
          end
        end
      end
      if (spilled_q) begin
        res1_d = gres;
      end else begin
        res0_d = gres;
      end
      two_d = spilled_q;
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DISCARD:   discard_d = cfg_wdata_i;
        CFG_LOW_WATER: lw_d = cfg_wdata_i[LW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    res0_o = res0_q;
    res0_o.refill_needed = refill_q;
    res0_o.last = !two_q;
    res1_o = res1_q;
    res1_o.refill_needed = refill_q;
    res1_o.last = 1'b1;
  end

  assign two_o = two_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q <= '0;
      ver_q <= '0;
      refill_q <= 1'b0;
      spilled_q <= 1'b0;
      discard_q <= DISCARD_RESET;
      lw_q <= LOW_WATER_RESET;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q <= cnt_d;
      ver_q <= ver_d;
      refill_q <= refill_d;
      spilled_q <= spilled_d;
      discard_q <= discard_d;
      lw_q <= lw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    need_q <= need_d;
    room_q <= room_d;
    res0_q <= res0_d;
    res1_q <= res1_d;
    two_q <= two_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[head_q];
  end

endmodule

// ===== rtl/cqsa_outq.sv =====
module cqsa_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 two_i,
  input  cqsa_pkg::out_item_t  res0_i,
  input  cqsa_pkg::out_item_t  res1_i,
  output logic                 push_ok_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cqsa_pkg::out_item_t  out_data_o
);
  import cqsa_pkg::*;

  out_item_t  slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o = slot0_q;
  assign pop = out_valid_o && !out_stall_i;
  assign push_ok_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && !two_i);

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d = cnt_q;
    if (pop) begin
      slot0_d = slot1_q;
      cnt_d = cnt_d - 2'd1;
    end
    if (push_i) begin
      if (cnt_d == 2'd0) begin
        slot0_d = res0_i;
        slot1_d = res1_i;
      end else begin
        slot1_d = res0_i;
      end
      cnt_d = cnt_d + (two_i ? 2'd2 : 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

// ===== rtl/chunk_queue_space_allocator_unit.sv =====
// Chunk queue space allocator. Add items (func 0) push a chunk onto a
// QUEUE_DEPTH-entry queue; allocate items (func 1) round the request up to
// ALIGN_BYTES and take it from the head chunk, spilling into the next chunk
// when the head runs short, so an allocate gives one or two result items
// and every other item gives one. Items are handled one at a time: an add,
// an error and a spill with no next chunk pass the room and decide states,
// an allocate served from the head passes the grant state too, and a spill
// into the next chunk then fetch, room and grant; the next item is taken
// once the results are queued. The pace is set by the chunk memory, whose
// registered read of the head must come back before room can be worked out
// and written back. A two-entry output queue holds results so the next
// item can be accepted while they wait to be taken.
// The chunk memory is not cleared at reset; only queued entries are read.
// Configuration writes belong in idle periods.
module chunk_queue_space_allocator_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ALIGN_BYTES = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  cqsa_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output cqsa_pkg::out_item_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [cqsa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cqsa_pkg::DATA_W-1:0]     cfg_wdata_i
);
  import cqsa_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  out_item_t res0, res1;
  logic      two;
  logic      push_ok;

  cqsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .push_ok_i  (push_ok),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cqsa_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res0_o      (res0),
    .res1_o      (res1),
    .two_o       (two)
  );

  cqsa_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd.push),
    .two_i       (two),
    .res0_i      (res0),
    .res1_i      (res1),
    .push_ok_o   (push_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/tb_chunk_queue_space_allocator_unit.sv =====
module tb_chunk_queue_space_allocator_unit;
  import cqsa_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int ALIGN_BYTES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 12;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_DISCARD;
  logic [DATA_W-1:0] cfg_wdata_i = '0;

  chunk_queue_space_allocator_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ALIGN_BYTES(ALIGN_BYTES)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  in_item_t cmd_q[$];
  out_item_t reply_q[$];
  int bad_cnt = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // allocator shadow state
  entry_t chunk_mem[QUEUE_DEPTH];
  int unsigned q_head = 0;
  int unsigned q_tail = 0;
  int unsigned q_count = 0;
  logic [VER_W-1:0] ver_cnt = '0;
  logic [DATA_W-1:0] discard_lvl = DISCARD_RESET;
  logic [LW_W-1:0] low_water = LOW_WATER_RESET;
  logic refill_hit;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint head_room();
    return longint'({32'd0, chunk_mem[q_head].size}) - longint'({32'd0, chunk_mem[q_head].fill});
  endfunction

  function automatic out_item_t take_from_head(logic [DATA_W-1:0] len);
    out_item_t r;
    r = '0;
    ver_cnt = ver_cnt + 1;
    r.grant_valid = 1'b1;
    r.grant_chunk = chunk_mem[q_head].id;
    r.grant_offset = chunk_mem[q_head].fill;
    r.grant_length = len;
    r.grant_version = ver_cnt;
    r.status = ST_OK;
    chunk_mem[q_head].fill = chunk_mem[q_head].fill + len;
    return r;
  endfunction

  function automatic void retire_head();
    q_head = (q_head + 1) % QUEUE_DEPTH;
    if (q_count > 0) q_count--;
    if (q_count < low_water) refill_hit = 1'b1;
  endfunction

  // works out the result items of one accepted item and queues them
  function automatic void predict_reply(in_item_t it);
    out_item_t staged[$];
    out_item_t r;
    logic [63:0] need;
    longint room;
    status_e st;
    bit failed;
    refill_hit = 1'b0;
    failed = 1'b0;
    st = ST_OK;
    if (it.func == FUNC_ADD) begin
      if (q_count >= QUEUE_DEPTH) begin
        st = ST_FULL;
      end else begin
        chunk_mem[q_tail] = '{it.chunk_id, it.chunk_bytes, it.chunk_fill_start};
        q_tail = (q_tail + 1) % QUEUE_DEPTH;
        q_count++;
      end
      failed = 1'b1;
    end else begin
      need = ({33'd0, it.request_bytes} + 64'(ALIGN_BYTES - 1)) & ~64'(ALIGN_BYTES - 1);
      if (q_count > 0) begin
        room = head_room();
        if (room < longint'(need)) begin
          if (!it.normal_priority && q_count <= 1) begin
            st = ST_RETRY;
            failed = 1'b1;
          end else if (room <= 0) begin
            st = ST_CORRUPT;
            failed = 1'b1;
          end else begin
            // head gives all it has, the rest spills into the next chunk
            staged.push_back(take_from_head(32'(room)));
            need = need - 64'(room);
            retire_head();
          end
        end
      end
      if (!failed && q_count == 0) begin
        st = it.normal_priority ? ST_NO_SPACE : ST_RETRY;
        failed = 1'b1;
      end
      if (!failed) begin
        room = head_room();
        if (longint'(need) > room) begin
          st = ST_RETRY;
          failed = 1'b1;
        end else begin
          staged.push_back(take_from_head(need[31:0]));
          if (head_room() < longint'({32'd0, discard_lvl})) retire_head();
        end
      end
    end
    if (failed) begin
      r = '0;
      r.status = st;
      staged.push_back(r);
    end
    foreach (staged[k]) begin
      r = staged[k];
      r.refill_needed = refill_hit;
      r.last = (k == staged.size() - 1);
      reply_q.push_back(r);
    end
  endfunction

  function automatic string show_reply(out_item_t r);
    return $sformatf("gv=%0b id=%h off=%h len=%h ver=%h st=%0d refill=%0b last=%0b",
                     r.grant_valid, r.grant_chunk, r.grant_offset, r.grant_length,
                     r.grant_version, r.status, r.refill_needed, r.last);
  endfunction

  // item source
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (cmd_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i <= cmd_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result sink back-pressure
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result checking, then prediction for the item taken at this edge
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (reply_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10) $display("unexpected result item: %s", show_reply(out_data_o));
        end else begin
          want = reply_q.pop_front();
          if (want.grant_valid !== out_data_o.grant_valid ||
              want.grant_chunk !== out_data_o.grant_chunk ||
              want.grant_offset !== out_data_o.grant_offset ||
              want.grant_length !== out_data_o.grant_length ||
              want.grant_version !== out_data_o.grant_version ||
              want.status !== out_data_o.status ||
              want.refill_needed !== out_data_o.refill_needed ||
              want.last !== out_data_o.last) begin
            bad_cnt++;
            if (bad_cnt <= 10) begin
              $display("result mismatch at %0t", $time);
              $display("  expected %s", show_reply(want));
              $display("  actual   %s", show_reply(out_data_o));
            end
          end
        end
      end
      if (in_valid_i && !in_stall_o) predict_reply(in_data_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", quiet_cycles);
      $display("chunk_queue_space_allocator_unit regression: fail");
      $finish;
    end
  end

  function automatic in_item_t junk_item();
    in_item_t it;
    logic [31:0] w;
    w = $urandom;
    it.func = w[0];
    it.normal_priority = w[1];
    it.chunk_id = $urandom;
    it.chunk_bytes = $urandom;
    it.chunk_fill_start = $urandom;
    w = $urandom;
    it.request_bytes = w[30:0];
    return it;
  endfunction

  function automatic in_item_t add_item(logic [31:0] id, logic [31:0] bytes, logic [31:0] fill);
    in_item_t it;
    it = junk_item();
    it.func = FUNC_ADD;
    it.chunk_id = id;
    it.chunk_bytes = bytes;
    it.chunk_fill_start = fill;
    return it;
  endfunction

  function automatic in_item_t alloc_item(logic [REQ_W-1:0] req, logic normal);
    in_item_t it;
    it = junk_item();
    it.func = FUNC_ALLOC;
    it.request_bytes = req;
    it.normal_priority = normal;
    return it;
  endfunction

  function automatic in_item_t rand_add();
    int unsigned sel;
    logic [31:0] bytes;
    logic [31:0] fill;
    sel = $urandom_range(0, 99);
    if (sel < 4) begin
      bytes = $urandom;
      fill = $urandom_range(0, bytes);
    end else begin
      bytes = $urandom_range(1, 600);
      // a full chunk only gets cleared out when the discard level is nonzero
      if (discard_lvl != 0 && sel < 12) fill = bytes;
      else fill = $urandom_range(0, bytes - 1);
    end
    return add_item($urandom, bytes, fill);
  endfunction

  function automatic in_item_t rand_alloc();
    int unsigned sel;
    logic [31:0] w;
    sel = $urandom_range(0, 99);
    w = $urandom;
    if (sel < 8) w = w;
    else if (sel < 16) w = '0;
    else w = $urandom_range(1, 300);
    return alloc_item(w[30:0], $urandom_range(0, 3) != 0);
  endfunction

  // bursts of adds followed by allocations, now and then enough adds to overflow
  task automatic queue_random(int n);
    int made;
    int n_add;
    int n_alloc;
    made = 0;
    while (made < n) begin
      n_add = $urandom_range(0, 3);
      if ($urandom_range(0, 19) == 0) n_add = 18;
      n_alloc = $urandom_range(1, 6);
      repeat (n_add) begin
        cmd_q.push_back(rand_add());
        made++;
      end
      repeat (n_alloc) begin
        cmd_q.push_back(rand_alloc());
        made++;
      end
    end
  endtask

  task automatic settle();
    while (cmd_q.size() > 0 || in_valid_i || reply_q.size() > 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DISCARD) discard_lvl = val;
    else low_water = val[LW_W-1:0];
    @(negedge clk_i);
  endtask

  task automatic random_phase(int idle, int stall, int n);
    idle_pct = idle;
    stall_pct = stall;
    queue_random(n);
    settle();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty queue, extreme sizes, low priority limits, spills, full queue
    cmd_q.push_back(alloc_item('1, 1'b1));
    cmd_q.push_back(alloc_item('0, 1'b0));
    cmd_q.push_back(add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
    cmd_q.push_back(alloc_item('0, 1'b1));
    cmd_q.push_back(alloc_item('1, 1'b0));
    cmd_q.push_back(alloc_item('1, 1'b0));
    cmd_q.push_back(alloc_item('1, 1'b1));
    for (int i = 0; i < QUEUE_DEPTH + 1; i++) begin
      cmd_q.push_back(add_item(32'h100 + i, 32'(8 * (i + 1)), 32'h0));
    end
    // spill from the head into a next chunk that is too small
    cmd_q.push_back(alloc_item(31'd30, 1'b1));
    settle();

    write_reg(CFG_DISCARD, 32'd32);
    write_reg(CFG_LOW_WATER, 32'd4);
    hold_asked = hold_asked + 1;
    random_phase(0, 0, 100);

    write_reg(CFG_DISCARD, 32'hFFFF_FFFF);
    write_reg(CFG_LOW_WATER, 32'd16);
    random_phase(82, 0, 110);

    write_reg(CFG_DISCARD, 32'd0);
    write_reg(CFG_LOW_WATER, 32'd0);
    random_phase(0, 82, 110);

    write_reg(CFG_DISCARD, 32'($urandom_range(1, 255)));
    write_reg(CFG_LOW_WATER, 32'($urandom_range(0, 16)));
    random_phase(36, 36, 150);

    write_reg(CFG_DISCARD, $urandom);
    write_reg(CFG_LOW_WATER, 32'($urandom_range(0, 16)));
    random_phase(36, 36, 130);

    // empty the queue with zero-byte grants, then put a corrupt chunk at the head
    write_reg(CFG_DISCARD, 32'hFFFF_FFFF);
    write_reg(CFG_LOW_WATER, 32'd2);
    idle_pct = 0;
    stall_pct = 0;
    repeat (QUEUE_DEPTH) cmd_q.push_back(alloc_item('0, 1'b1));
    cmd_q.push_back(add_item(32'h5A, 32'd16, 32'd24));
    cmd_q.push_back(add_item(32'h5B, 32'd64, 32'd0));
    cmd_q.push_back(alloc_item(31'd8, 1'b1));
    cmd_q.push_back(alloc_item(31'd1, 1'b0));
    settle();

    if (bad_cnt == 0) begin
      $display("chunk_queue_space_allocator_unit regression: pass");
    end else begin
      $display("chunk_queue_space_allocator_unit regression: fail");
    end
    $finish;
  end

endmodule
